FILE: src/sxfb_pkg.sv
// sxfb_pkg: shared constants and types for the sprite xor framebuffer
// screen geometry, request mode codes and sequencer states; no dependencies
`timescale 1ns / 1ps

package sxfb_pkg;

  localparam int unsigned SCREEN_WIDTH  = 64;
  localparam int unsigned SCREEN_HEIGHT = 32;

  // row address and column index widths
  localparam int unsigned ROW_W = $clog2(SCREEN_HEIGHT);
  localparam int unsigned COL_W = $clog2(SCREEN_WIDTH);

  localparam int unsigned SPRITE_W = 8;
  localparam int unsigned OFFSET_W = 4;
  localparam int unsigned MODE_W   = 2;

  typedef logic [SCREEN_WIDTH-1:0] row_word_t;
  typedef logic [ROW_W-1:0]        row_addr_t;

  typedef enum logic [MODE_W-1:0] {
    MODE_CLEAR  = 2'd0,
    MODE_DRAW   = 2'd1,
    MODE_READ   = 2'd2,
    MODE_UNUSED = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CLEAR,
    ST_MODIFY,
    ST_EMIT
  } state_e;

endpackage

FILE: src/sprite_xor_framebuffer.sv
// sprite_xor_framebuffer: 64x32 one-bit framebuffer with xor sprite rows
// depends on sxfb_pkg; holds the row memory and its sequencer
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid_i / in_ready_o) carries one request per beat:
//   mode 0 clears the screen, mode 1 xors one 8-pixel sprite row at
//   (sprite_x mod 64, sprite_y mod 32 + row_offset), mode 2 reads one row.
//   Mode 3 is dropped. Output channel (out_valid_o / out_ready_i) carries
//   the collision flag after a draw beat marked last_row, or a 64-bit row
//   for a read (bit 63 leftmost); the other field is zero.
//   Steps per request, set by the single read/write port of the row memory
//   and the sequencer that walks it: a draw row reads, then xors and writes
//   back, plus an emit step when a result is produced; a read reads, then
//   emits; clear writes one row per cycle over all rows; mode 3 takes no
//   step; a row below the bottom edge skips the memory (emit if last_row).
//   The input is not ready while a request is in progress. A result sits in
//   the output register until taken; a finished item waits in its last step
//   while the receiver stalls, and the next request is accepted at the edge
//   after the one that frees that register. Reset clears all rows (per-row
//   valid bits) and the collision flag at once, with no sweep.

module sprite_xor_framebuffer (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic [sxfb_pkg::MODE_W-1:0]          mode_i,
  input  logic [7:0]                           sprite_x_i,
  input  logic [7:0]                           sprite_y_i,
  input  logic [sxfb_pkg::OFFSET_W-1:0]        row_offset_i,
  input  logic [sxfb_pkg::SPRITE_W-1:0]        sprite_byte_i,
  input  logic                                 last_row_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 collision_o,
  output logic [sxfb_pkg::SCREEN_WIDTH-1:0]    row_pixels_o
);

  localparam int unsigned SumW = sxfb_pkg::ROW_W + 1;

  sxfb_pkg::state_e    state_q, state_d;
  logic                coll_q, coll_d;
  logic                out_valid_q, out_valid_d;
  logic                out_coll_q, out_coll_d;
  sxfb_pkg::row_word_t out_pix_q, out_pix_d;
  logic                res_coll_q, res_coll_d;
  sxfb_pkg::row_word_t res_pix_q, res_pix_d;
  sxfb_pkg::row_addr_t clr_cnt_q, clr_cnt_d;
  logic [sxfb_pkg::SCREEN_HEIGHT-1:0] row_vld_q;

  // latched request fields
  logic                              is_read_q;
  sxfb_pkg::row_addr_t               addr_q;
  logic [sxfb_pkg::COL_W-1:0]        col_q;
  logic [sxfb_pkg::SPRITE_W-1:0]     byte_q;
  logic                              last_q;

  // row memory, one port
  sxfb_pkg::row_word_t mem_q [sxfb_pkg::SCREEN_HEIGHT];
  sxfb_pkg::row_word_t rd_q;
  logic                rd_en, wr_en;
  sxfb_pkg::row_addr_t rd_addr, wr_addr;
  sxfb_pkg::row_word_t wr_data;

  logic                load_in;
  logic [SumW-1:0]     row_sum;
  sxfb_pkg::row_addr_t in_row;
  sxfb_pkg::row_word_t cur_row, pattern;
  logic                hit, out_free;

  assign row_sum = {1'b0, sprite_y_i[sxfb_pkg::ROW_W-1:0]} + SumW'(row_offset_i);
  assign in_row  = (mode_i == sxfb_pkg::MODE_READ) ?
                   sprite_y_i[sxfb_pkg::ROW_W-1:0] : row_sum[sxfb_pkg::ROW_W-1:0];

  // rows never written since reset read as zero
  assign cur_row  = row_vld_q[addr_q] ? rd_q : '0;
  assign pattern  = {byte_q, {(sxfb_pkg::SCREEN_WIDTH-sxfb_pkg::SPRITE_W){1'b0}}} >> col_q;
  assign hit      = |(cur_row & pattern);
  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d     = state_q;
    coll_d      = coll_q;
    res_coll_d  = res_coll_q;
    res_pix_d   = res_pix_q;
    clr_cnt_d   = clr_cnt_q;
    out_valid_d = out_valid_q;
    out_coll_d  = out_coll_q;
    out_pix_d   = out_pix_q;
    in_ready_o  = 1'b0;
    load_in     = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = in_row;
    wr_en       = 1'b0;
    wr_addr     = addr_q;
    wr_data     = cur_row ^ pattern;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      sxfb_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (mode_i)
            sxfb_pkg::MODE_CLEAR: begin
              clr_cnt_d = '0;
              state_d   = sxfb_pkg::ST_CLEAR;
            end
            sxfb_pkg::MODE_DRAW: begin
              load_in = 1'b1;
              if (row_sum >= SumW'(sxfb_pkg::SCREEN_HEIGHT)) begin
                // clipped row: only the last-row report remains
                if (last_row_i) begin
                  res_coll_d = coll_q;
                  res_pix_d  = '0;
                  coll_d     = 1'b0;
                  state_d    = sxfb_pkg::ST_EMIT;
                end
              end else begin
                rd_en   = 1'b1;
                state_d = sxfb_pkg::ST_MODIFY;
              end
            end
            sxfb_pkg::MODE_READ: begin
              load_in = 1'b1;
              rd_en   = 1'b1;
              state_d = sxfb_pkg::ST_MODIFY;
            end
            default: begin
            end
          endcase
        end
      end
      sxfb_pkg::ST_MODIFY: begin
        if (is_read_q) begin
          res_coll_d = 1'b0;
          res_pix_d  = cur_row;
          state_d    = sxfb_pkg::ST_EMIT;
        end else begin
          wr_en = 1'b1;
          if (last_q) begin
            res_coll_d = coll_q | hit;
            res_pix_d  = '0;
            coll_d     = 1'b0;
            state_d    = sxfb_pkg::ST_EMIT;
          end else begin
            coll_d  = coll_q | hit;
            state_d = sxfb_pkg::ST_IDLE;
          end
        end
      end
      sxfb_pkg::ST_CLEAR: begin
        wr_en     = 1'b1;
        wr_addr   = clr_cnt_q;
        wr_data   = '0;
        clr_cnt_d = clr_cnt_q + 1'b1;
        if (clr_cnt_q == sxfb_pkg::ROW_W'(sxfb_pkg::SCREEN_HEIGHT - 1)) begin
          state_d = sxfb_pkg::ST_IDLE;
        end
      end
      sxfb_pkg::ST_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_coll_d  = res_coll_q;
          out_pix_d   = res_pix_q;
          state_d     = sxfb_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = sxfb_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sxfb_pkg::ST_IDLE;
      coll_q      <= 1'b0;
      out_valid_q <= 1'b0;
      clr_cnt_q   <= '0;
      row_vld_q   <= '0;
    end else begin
      state_q     <= state_d;
      coll_q      <= coll_d;
      out_valid_q <= out_valid_d;
      clr_cnt_q   <= clr_cnt_d;
      if (wr_en) begin
        row_vld_q[wr_addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    out_coll_q <= out_coll_d;
    out_pix_q  <= out_pix_d;
    res_coll_q <= res_coll_d;
    res_pix_q  <= res_pix_d;
    if (load_in) begin
      is_read_q <= (mode_i == sxfb_pkg::MODE_READ);
      addr_q    <= in_row;
      col_q     <= sprite_x_i[sxfb_pkg::COL_W-1:0];
      byte_q    <= sprite_byte_i;
      last_q    <= last_row_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem_q[rd_addr];
    end
  end

  assign out_valid_o  = out_valid_q;
  assign collision_o  = out_coll_q;
  assign row_pixels_o = out_pix_q;

  // unused mode code is dropped without stalling the input
  a_mode3_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == sxfb_pkg::MODE_UNUSED) |=> in_ready_o)
    else $error("unused mode stalled the input");

  // a clear request blocks the input while the sweep runs
  a_clear_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && mode_i == sxfb_pkg::MODE_CLEAR) |=> ##1 !in_ready_o)
    else $error("input accepted during clear sweep");

  // sticky flag is dropped once the last row is reported
  a_coll_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sxfb_pkg::ST_MODIFY && !is_read_q && last_q) |=> !coll_q)
    else $error("collision flag kept after last row");

  // a new result only comes out of the emit step
  a_emit_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == sxfb_pkg::ST_EMIT))
    else $error("result beat from wrong step");

  // memory is written only by a draw or a clear
  a_write_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en |-> (state_q == sxfb_pkg::ST_CLEAR ||
               (state_q == sxfb_pkg::ST_MODIFY && !is_read_q)))
    else $error("row memory written outside draw or clear");

endmodule

FILE: sim/tb_sprite_xor_framebuffer.sv
// tb_sprite_xor_framebuffer: self-checking testbench for the sprite xor framebuffer
// depends on sxfb_pkg and sprite_xor_framebuffer; keeps its own frame copy and
// checks every output beat against it under random sender idling and receiver stalls
`timescale 1ns / 1ps

module tb_sprite_xor_framebuffer;

  localparam int unsigned LIMIT_CYCLES = 400000;
  localparam int unsigned SETTLE_CYCLES = 40;  // covers a clear walking all rows
  localparam int unsigned BEATS_PER_PHASE = 270;

  typedef struct packed {
    logic                collision;
    sxfb_pkg::row_word_t row_pixels;
  } frame_result_t;

  logic                               clk_i = 1'b0;
  logic                               rst_ni = 1'b0;
  logic                               in_valid_i;
  logic                               in_ready_o;
  logic [sxfb_pkg::MODE_W-1:0]        mode_i;
  logic [7:0]                         sprite_x_i;
  logic [7:0]                         sprite_y_i;
  logic [sxfb_pkg::OFFSET_W-1:0]      row_offset_i;
  logic [sxfb_pkg::SPRITE_W-1:0]      sprite_byte_i;
  logic                               last_row_i;
  logic                               out_valid_o;
  logic                               out_ready_i = 1'b0;
  logic                               collision_o;
  logic [sxfb_pkg::SCREEN_WIDTH-1:0]  row_pixels_o;

  // predicted frame contents and sticky erase flag
  sxfb_pkg::row_word_t shadow_frame [sxfb_pkg::SCREEN_HEIGHT];
  logic                shadow_erased;
  frame_result_t       pending_results [$];

  int          error_count = 0;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          beats_sent = 0;
  int unsigned cycle_count = 0;

  sprite_xor_framebuffer dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .mode_i        (mode_i),
    .sprite_x_i    (sprite_x_i),
    .sprite_y_i    (sprite_y_i),
    .row_offset_i  (row_offset_i),
    .sprite_byte_i (sprite_byte_i),
    .last_row_i    (last_row_i),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .collision_o   (collision_o),
    .row_pixels_o  (row_pixels_o)
  );

  always #2 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
  end

  // apply one accepted request to the shadow frame
  function automatic void update_frame(logic [sxfb_pkg::MODE_W-1:0] mode, logic [7:0] x,
                                       logic [7:0] y, logic [sxfb_pkg::OFFSET_W-1:0] off,
                                       logic [sxfb_pkg::SPRITE_W-1:0] pixels,
                                       logic last);
    int                  row;
    sxfb_pkg::row_word_t pattern;
    frame_result_t       res;
    row = int'(y[sxfb_pkg::ROW_W-1:0]) + int'(off);
    res = '0;
    case (mode)
      sxfb_pkg::MODE_CLEAR: begin
        for (int r = 0; r < sxfb_pkg::SCREEN_HEIGHT; r++) shadow_frame[r] = '0;
      end
      sxfb_pkg::MODE_DRAW: begin
        if (row < sxfb_pkg::SCREEN_HEIGHT) begin
          // pixels past the right edge fall off the shift
          pattern = {pixels, {(sxfb_pkg::SCREEN_WIDTH-sxfb_pkg::SPRITE_W){1'b0}}}
                    >> x[sxfb_pkg::COL_W-1:0];
          if ((shadow_frame[row] & pattern) != '0) shadow_erased = 1'b1;
          shadow_frame[row] ^= pattern;
        end
        if (last) begin
          res.collision = shadow_erased;
          pending_results.push_back(res);
          shadow_erased = 1'b0;
        end
      end
      sxfb_pkg::MODE_READ: begin
        res.row_pixels = shadow_frame[y[sxfb_pkg::ROW_W-1:0]];
        pending_results.push_back(res);
      end
      default: ;
    endcase
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_beat(logic [sxfb_pkg::MODE_W-1:0] mode, logic [7:0] x,
                           logic [7:0] y, logic [sxfb_pkg::OFFSET_W-1:0] off,
                           logic [sxfb_pkg::SPRITE_W-1:0] pixels, logic last);
    bit taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    mode_i        <= mode;
    sprite_x_i    <= x;
    sprite_y_i    <= y;
    row_offset_i  <= off;
    sprite_byte_i <= pixels;
    last_row_i    <= last;
    do begin
      @(negedge clk_i);
      taken = in_ready_o;
      @(posedge clk_i);
    end while (!taken);
    update_frame(mode, x, y, off, pixels, last);
    if (mode != sxfb_pkg::MODE_UNUSED) beats_sent++;
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending_results.size() != 0);
  endtask

  always @(negedge clk_i) begin : check_result
    frame_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat collision %0b row %h", $time, collision_o,
                 row_pixels_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (collision_o !== want.collision) begin
          $display("%0t: collision expected %0b actual %0b", $time, want.collision,
                   collision_o);
          error_count++;
        end
        if (row_pixels_o !== want.row_pixels) begin
          $display("%0t: row_pixels expected %h actual %h", $time, want.row_pixels,
                   row_pixels_o);
          error_count++;
        end
      end
    end
  end

  task automatic test_power_on_rows();
    send_beat(sxfb_pkg::MODE_READ, 8'd0,   8'd0,   4'd0, 8'h00, 1'b0);
    send_beat(sxfb_pkg::MODE_READ, 8'd200, 8'd255, 4'd0, 8'h00, 1'b1);
  endtask

  task automatic test_directed_cases();
    // draw, read back, erase again for a collision
    send_beat(sxfb_pkg::MODE_DRAW,   8'd0,   8'd0,   4'd0,  8'hFF, 1'b1);
    send_beat(sxfb_pkg::MODE_READ,   8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
    send_beat(sxfb_pkg::MODE_DRAW,   8'd0,   8'd0,   4'd0,  8'hFF, 1'b1);
    send_beat(sxfb_pkg::MODE_READ,   8'd0,   8'd32,  4'd0,  8'h00, 1'b0);
    // origin 255 wraps to column 63, right edge clips
    send_beat(sxfb_pkg::MODE_DRAW,   8'd255, 8'd1,   4'd0,  8'hFF, 1'b1);
    send_beat(sxfb_pkg::MODE_DRAW,   8'd63,  8'd1,   4'd0,  8'h80, 1'b1);
    // multi-row sprite, flag stays set over the rows until the last one
    send_beat(sxfb_pkg::MODE_DRAW,   8'd60,  8'd2,   4'd0,  8'hA5, 1'b0);
    send_beat(sxfb_pkg::MODE_DRAW,   8'd60,  8'd2,   4'd1,  8'h5A, 1'b0);
    send_beat(sxfb_pkg::MODE_DRAW,   8'd60,  8'd2,   4'd0,  8'h81, 1'b0);
    send_beat(sxfb_pkg::MODE_DRAW,   8'd60,  8'd2,   4'd2,  8'h00, 1'b1);
    // zero-height sprite
    send_beat(sxfb_pkg::MODE_DRAW,   8'd10,  8'd10,  4'd0,  8'h00, 1'b1);
    // rows below the bottom edge are skipped
    send_beat(sxfb_pkg::MODE_DRAW,   8'd0,   8'd255, 4'd15, 8'hFF, 1'b0);
    send_beat(sxfb_pkg::MODE_DRAW,   8'd0,   8'd31,  4'd1,  8'hFF, 1'b1);
    send_beat(sxfb_pkg::MODE_DRAW,   8'd0,   8'd31,  4'd0,  8'hFF, 1'b1);
    send_beat(sxfb_pkg::MODE_READ,   8'd0,   8'd31,  4'd0,  8'h00, 1'b0);
    // unused mode leaves everything alone
    send_beat(sxfb_pkg::MODE_UNUSED, 8'd0,   8'd31,  4'd0,  8'hFF, 1'b1);
    send_beat(sxfb_pkg::MODE_DRAW,   8'd7,   8'd16,  4'd15, 8'hC3, 1'b1);
    send_beat(sxfb_pkg::MODE_READ,   8'd0,   8'd31,  4'd0,  8'h00, 1'b0);
    // clear keeps the pending erase flag
    send_beat(sxfb_pkg::MODE_DRAW,   8'd0,   8'd5,   4'd0,  8'hFF, 1'b0);
    send_beat(sxfb_pkg::MODE_DRAW,   8'd0,   8'd5,   4'd0,  8'hFF, 1'b0);
    send_beat(sxfb_pkg::MODE_CLEAR,  8'd0,   8'd0,   4'd0,  8'h00, 1'b0);
    send_beat(sxfb_pkg::MODE_DRAW,   8'd0,   8'd5,   4'd0,  8'h00, 1'b1);
    send_beat(sxfb_pkg::MODE_READ,   8'd0,   8'd31,  4'd0,  8'h00, 1'b0);
    send_beat(sxfb_pkg::MODE_READ,   8'd0,   8'd2,   4'd0,  8'h00, 1'b0);
  endtask

  task automatic send_sprite(logic [7:0] x, logic [7:0] y, int height);
    if (height == 0) begin
      send_beat(sxfb_pkg::MODE_DRAW, x, y, 4'd0, 8'h00, 1'b1);
    end else begin
      for (int i = 0; i < height; i++)
        send_beat(sxfb_pkg::MODE_DRAW, x, y, sxfb_pkg::OFFSET_W'(i),
                  sxfb_pkg::SPRITE_W'($urandom_range(255)), i == height - 1);
    end
  endtask

  // mostly whole sprites with reads in between, some stray rows and noise
  task automatic test_random_traffic(int idle_pct, int stall_pct);
    int pick;
    int goal;
    sender_idle_pct    = idle_pct;
    receiver_stall_pct = stall_pct;
    goal = beats_sent + BEATS_PER_PHASE;
    while (beats_sent < goal) begin
      pick = $urandom_range(99);
      if (pick < 62)
        send_sprite(8'($urandom_range(255)), 8'($urandom_range(255)),
                    $urandom_range(16));
      else if (pick < 87)
        send_beat(sxfb_pkg::MODE_READ, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  4'($urandom_range(15)), 8'($urandom_range(255)), 1'($urandom));
      else if (pick < 95)
        send_beat(sxfb_pkg::MODE_DRAW, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  4'($urandom_range(15)), 8'($urandom_range(255)), 1'($urandom));
      else if (pick < 98)
        send_beat(sxfb_pkg::MODE_UNUSED, 8'($urandom_range(255)),
                  8'($urandom_range(255)), 4'($urandom_range(15)),
                  8'($urandom_range(255)), 1'($urandom));
      else
        send_beat(sxfb_pkg::MODE_CLEAR, 8'($urandom_range(255)), 8'($urandom_range(255)),
                  4'($urandom_range(15)), 8'($urandom_range(255)), 1'($urandom));
    end
  endtask

  initial begin
    in_valid_i    <= 1'b0;
    mode_i        <= sxfb_pkg::MODE_CLEAR;
    sprite_x_i    <= '0;
    sprite_y_i    <= '0;
    row_offset_i  <= '0;
    sprite_byte_i <= '0;
    last_row_i    <= 1'b0;
    for (int r = 0; r < sxfb_pkg::SCREEN_HEIGHT; r++) shadow_frame[r] = '0;
    shadow_erased = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_power_on_rows();
    test_directed_cases();
    test_random_traffic(0, 0);
    drain_results();
    test_random_traffic(59, 0);
    test_random_traffic(0, 59);
    drain_results();
    test_random_traffic(19, 19);

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
